// File: rtl/assert_macros.svh
// Assertion macros used by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int DEF_MAX_SLOTS = 1024;
    localparam logic [10:0] MOD_RESET = 11'd1024;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FOUND    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_ERASED   = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] key;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] amount;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PRD,
        S_PCHK,
        S_ERD,
        S_ECHK,
        S_EDIV,
        S_ECLR,
        S_OUT
    } t_state;

endpackage

// File: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// An item hashes its key, then reads and checks each probed slot in turn (S_PRD, S_PCHK),
// and the result is loaded into the output register from S_OUT. Erase reads each cluster entry
// after the match (its home is rehashed), then any empty slot that ends it, and clears the gap.
// Throughput: one item at a time; the key-mod-modulus unit (one bit per cycle) dominates.
// Reset: synchronous, active low; a clearing pass then empties
// every slot, and no item is accepted until it finishes.
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lpht_pkg::DEF_MAX_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lpht_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lpht_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_data
);
    import lpht_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int MW = $clog2(MAX_SLOTS + 1);
    localparam int CW = (MW > 11) ? MW : 11;

    // The slot memory keeps the valid flag in bit 31 and the key below it.
    logic [31:0] r_mem [MAX_SLOTS];
    logic [31:0] r_rd_data;

    t_state     r_state, n_state;
    logic [10:0] r_modulus;
    logic [MW-1:0] r_mod, eff_mod;
    logic [1:0]  r_kind, n_kind;
    logic [30:0] r_key, n_key;
    logic [30:0] r_cand, n_cand;
    logic [AW-1:0] r_idx, n_idx, r_home, n_home, r_gap, n_gap, r_moved, n_moved;
    logic [AW-1:0] r_clr;
    t_out_item  r_res, n_res;
    logic       r_out_valid;
    t_out_item  r_out_data;

    // Memory and divider control.
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;
    logic          div_start;
    logic [30:0]   div_dividend;
    logic [MW-1:0] div_divisor;
    t_mod_stat     div_stat;
    logic [AW-1:0] div_rem;
    logic          load_out;

    logic [AW-1:0] idx_next;
    logic          rd_valid, rd_match, can_move;
    logic [CW-1:0] m_ext;

    // The modulus saturates to one at zero and to MAX_SLOTS above it.
    always_comb begin
        m_ext = CW'(r_modulus);
        if (m_ext == '0) begin
            m_ext = CW'(1);
        end else if (m_ext > CW'(MAX_SLOTS)) begin
            m_ext = CW'(MAX_SLOTS);
        end
        eff_mod = MW'(m_ext);
    end

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v, input logic [MW-1:0] m);
        logic [MW-1:0] s;
        s = MW'(v) + MW'(1);
        return (s == m) ? '0 : AW'(s);
    endfunction

    // True when the entry at pos, whose home is h, may move back to gap.
    function automatic logic movable(input logic [AW-1:0] gap, input logic [AW-1:0] pos,
                                     input logic [AW-1:0] h);
        return (gap < pos && pos < h) || (pos < h && h <= gap) || (h <= gap && gap < pos);
    endfunction

    assign idx_next = wrap_inc(r_idx, r_mod);
    assign rd_valid = r_rd_data[31];
    assign rd_match = rd_valid && (r_rd_data[30:0] == r_key);
    assign can_move = movable(r_gap, r_idx, div_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    lpht_mod #(.MAX_SLOTS(MAX_SLOTS)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    // Next state and datapath.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_key   = r_key;
        n_cand  = r_cand;
        n_idx   = r_idx;
        n_home  = r_home;
        n_gap   = r_gap;
        n_moved = r_moved;
        n_res   = r_res;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_in_data.kind;
                    n_key   = i_in_data.key;
                    n_moved = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (div_stat.done) begin
                    n_idx   = div_rem;
                    n_home  = div_rem;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                // The probe ends at an empty slot, a matching key, or a full wrap.
                if (!rd_valid || rd_match || idx_next == r_home) begin
                    n_state = S_OUT;
                    n_res.amount = '0;
                    if (r_kind == KIND_INSERT) begin
                        if (!rd_valid) begin
                            n_res.status = ST_INSERTED;
                            n_res.amount = 10'(r_idx);
                        end else if (rd_match) begin
                            n_res.status = ST_PRESENT;
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end else if (r_kind == KIND_ERASE) begin
                        if (rd_match) begin
                            n_gap  = r_idx;
                            n_home = r_idx;
                            n_idx  = idx_next;
                            n_state = (idx_next == r_idx) ? S_ECLR : S_ERD;
                        end else begin
                            n_res.status = ST_MISSING;
                        end
                    end else begin
                        if (rd_match) begin
                            n_res.status = ST_FOUND;
                            n_res.amount = 10'(r_idx);
                        end else begin
                            n_res.status = ST_MISSING;
                        end
                    end
                end else begin
                    n_idx   = idx_next;
                    n_state = S_PRD;
                end
            end
            S_ERD: begin
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (!rd_valid) begin
                    n_state = S_ECLR;
                end else begin
                    n_cand  = r_rd_data[30:0];
                    n_state = S_EDIV;
                end
            end
            S_EDIV: begin
                if (div_stat.done) begin
                    if (can_move) begin
                        n_gap   = r_idx;
                        n_moved = r_moved + AW'(1);
                    end
                    n_idx   = idx_next;
                    n_state = (idx_next == r_home) ? S_ECLR : S_ERD;
                end
            end
            S_ECLR: begin
                n_res.status = ST_ERASED;
                n_res.amount = 10'(r_moved);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready   = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_gap;
        mem_raddr    = r_idx;
        mem_wdata    = '0;
        div_start    = 1'b0;
        div_dividend = i_in_data.key;
        div_divisor  = eff_mod;
        load_out     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                div_start  = i_in_valid;
            end
            S_PRD, S_ERD: begin
                mem_re = 1'b1;
            end
            S_PCHK: begin
                if (r_kind == KIND_INSERT && !rd_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = {1'b1, r_key};
                end
            end
            S_ECHK: begin
                if (rd_valid) begin
                    div_start    = 1'b1;
                    div_dividend = r_rd_data[30:0];
                    div_divisor  = r_mod;
                end
            end
            S_EDIV: begin
                // Shift the entry back into the gap; its old slot becomes the gap.
                if (div_stat.done && can_move) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_gap;
                    mem_wdata = {1'b1, r_cand};
                end
            end
            S_ECLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_gap;
            end
            S_OUT: begin
                load_out = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_cand  <= n_cand;
        r_idx   <= n_idx;
        r_home  <= n_home;
        r_gap   <= n_gap;
        r_moved <= n_moved;
        r_res   <= n_res;
        if (r_state == S_IDLE) begin
            r_mod <= eff_mod;
        end
        if (load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_IMPL(a_div_free, div_start, !div_stat.busy)
    `ASSERT_IMPL(a_no_write_idle, r_state == S_IDLE, !mem_we)
    `ASSERT_IMPL(a_idx_in_range, r_state == S_PCHK || r_state == S_ECHK, MW'(r_idx) < r_mod)
    `ASSERT_NEXT(a_out_loaded, load_out, o_out_valid && r_state == S_IDLE)

endmodule

// File: rtl/lpht_mod.sv
`timescale 1ns / 1ps
module lpht_mod #(
    parameter int MAX_SLOTS = lpht_pkg::DEF_MAX_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [30:0]                      i_dividend,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]   i_divisor,
    output lpht_pkg::t_mod_stat              o_stat,
    output logic [$clog2(MAX_SLOTS)-1:0]     o_rem
);
    import lpht_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int MW = $clog2(MAX_SLOTS + 1);

    // Restoring remainder, one dividend bit per cycle, MSB first.
    logic          r_busy, r_done;
    logic [4:0]    r_cnt;
    logic [30:0]   r_q;
    logic [MW-1:0] r_rem, r_div;
    logic [MW:0]   trial;

    assign trial = {r_rem, r_q[30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= {r_q[29:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= MW'(trial - {1'b0, r_div});
            end else begin
                r_rem <= MW'(trial);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = AW'(r_rem);

endmodule

// File: tb/sv/lpht_checker.sv
`timescale 1ns / 1ps
// Watches both item channels and the configuration port of the hash table.
// It keeps its own copy of the slot store, predicts one result per accepted
// input item and compares every accepted result with the oldest prediction.
module lpht_checker #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lpht_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lpht_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import lpht_pkg::*;

    logic [30:0] shadow_key [MAX_SLOTS];
    logic        shadow_used [MAX_SLOTS];
    logic [10:0] slot_count;
    t_out_item   awaited [$];
    int          fail_count;
    int          result_count;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
                 $realtime, result_count, what, got, want);
        fail_count = fail_count + 1;
    endtask

    // An entry at pos with home h may shift back into the hole at gap.
    function automatic bit may_shift(input int unsigned gap, input int unsigned pos,
                                     input int unsigned h);
        return (gap < pos && pos < h) || (pos < h && h <= gap) || (h <= gap && gap < pos);
    endfunction

    function automatic t_out_item apply_table_op(input logic [1:0] kind,
                                                 input logic [30:0] key);
        int unsigned m, home, i, n, slot, gap, moved;
        int          hit;
        bit          cleared;
        t_out_item   res;
        m = (slot_count == 0) ? 1 : ((slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count);
        home = key % m;
        hit = 2;
        slot = 0;
        for (n = 0; n < m && hit == 2; n++) begin
            i = (home + n) % m;
            if (!shadow_used[i]) begin
                hit = 0;
                slot = i;
            end else if (shadow_key[i] == key) begin
                hit = 1;
                slot = i;
            end
        end
        res.amount = '0;
        if (kind == KIND_INSERT) begin
            if (hit == 2) begin
                res.status = ST_FULL;
            end else if (hit == 1) begin
                res.status = ST_PRESENT;
            end else begin
                shadow_key[slot] = key;
                shadow_used[slot] = 1'b1;
                res.status = ST_INSERTED;
                res.amount = slot[9:0];
            end
        end else if (kind == KIND_ERASE) begin
            if (hit != 1) begin
                res.status = ST_MISSING;
            end else begin
                gap = slot;
                moved = 0;
                cleared = 1'b0;
                for (n = 1; n < m && !cleared; n++) begin
                    i = (slot + n) % m;
                    if (!shadow_used[i]) begin
                        shadow_used[gap] = 1'b0;
                        cleared = 1'b1;
                    end else if (may_shift(gap, i, shadow_key[i] % m)) begin
                        shadow_key[gap] = shadow_key[i];
                        gap = i;
                        moved++;
                    end
                end
                if (!cleared) shadow_used[gap] = 1'b0;
                res.status = ST_ERASED;
                res.amount = moved[9:0];
            end
        end else begin
            res.status = (hit == 1) ? ST_FOUND : ST_MISSING;
            if (hit == 1) res.amount = slot[9:0];
        end
        return res;
    endfunction

    initial begin
        fail_count = 0;
        result_count = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            slot_count <= MOD_RESET;
            for (int s = 0; s < MAX_SLOTS; s++) shadow_used[s] = 1'b0;
            awaited.delete();
        end else begin
            if (i_cfg_we) slot_count <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                awaited.push_back(apply_table_op(i_in_data.kind, i_in_data.key));
            if (i_out_valid && i_out_ready) begin
                result_count = result_count + 1;
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected result, status", i_out_data.status, 0);
                end else begin
                    want = awaited.pop_front();
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.amount !== want.amount)
                        report_mismatch("amount", i_out_data.amount, want.amount);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the linear-probing hash table. All prediction and
// comparison live in the checker; this module only makes traffic.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    // Kind three is not a named operation; the block treats it as a search.
    localparam logic [1:0] KIND_ALIAS = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [10:0] i_cfg_data;
    int          fail_count;
    int          pending;

    int          items_sent;
    int          settings_used;
    bit          steady;        // When set, neither side idles.
    int          ready_hold;
    logic [30:0] key_pool [];

    linear_probe_hash_table u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    lpht_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Unless steady is set, the result side draws a random stall after every accepted
    // result and holds ready low for its length.
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_hold <= 0;
        end else if (o_out_valid && i_out_ready) begin
            stall = steady ? 0 : $urandom_range(0, 4);
            ready_hold <= stall;
            i_out_ready <= (stall == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_out_ready <= (ready_hold == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Present one item and return at the edge that accepts it. Valid is left
    // high so that a following item with no gap keeps it up without a dip;
    // whoever comes next either replaces the payload or lowers valid.
    task automatic send_op(input logic [1:0] kind, input logic [30:0] key);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{kind: kind, key: key};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // The slot count may only change while the table is idle, so hold the
    // sender until every predicted result has come back, then let the
    // longest single-slot operation drain before the write.
    task automatic set_slot_count(input logic [10:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Draw a key pool for one phase. Every odd entry has its low ten bits below 16 so that
    // long clusters form even when the table is wide.
    task automatic fill_pool(input int size);
        key_pool = new[size];
        foreach (key_pool[k]) begin
            key_pool[k] = 31'($urandom);
            if (k % 2 == 1) key_pool[k][9:0] = 10'($urandom_range(0, 15));
        end
    endtask

    // Random traffic: inserts most often, while erases and searches keep the
    // table churning; a few items use the alias kind or a key outside the pool.
    task automatic run_phase(input logic [10:0] value, input int pool_size, input int count);
        int          pick;
        logic [1:0]  kind;
        logic [30:0] key;
        set_slot_count(value);
        fill_pool(pool_size);
        steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) kind = KIND_INSERT;
            else if (pick < 70) kind = KIND_SEARCH;
            else if (pick < 95) kind = KIND_ERASE;
            else kind = KIND_ALIAS;
            if ($urandom_range(0, 19) == 0) key = 31'($urandom);
            else key = key_pool[$urandom_range(0, pool_size - 1)];
            send_op(kind, key);
            if (n % 100 == 99) steady = ($urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        items_sent = 0;
        settings_used = 0;
        steady = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the widest table: extreme keys, every operation,
        // a duplicate insert, misses on search and erase, and the alias kind.
        set_slot_count(11'd1024);
        send_op(KIND_INSERT, 31'd0);
        send_op(KIND_INSERT, 31'h7FFF_FFFF);
        send_op(KIND_INSERT, 31'd1024);
        send_op(KIND_INSERT, 31'h7FFF_FFFF);
        send_op(KIND_SEARCH, 31'd1024);
        send_op(KIND_SEARCH, 31'h5555_5555);
        send_op(KIND_ALIAS, 31'd0);
        send_op(KIND_ERASE, 31'd0);
        send_op(KIND_SEARCH, 31'd1024);
        send_op(KIND_ERASE, 31'h2AAA_AAAA);

        // A single slot that still holds key 1024: both inserts find the table full.
        set_slot_count(11'd1);
        send_op(KIND_INSERT, 31'd77);
        send_op(KIND_INSERT, 31'd78);
        send_op(KIND_ERASE, 31'd77);

        // Three slots filled completely, so the erase scan wraps around
        // without meeting an empty slot and entries shift back.
        set_slot_count(11'd3);
        send_op(KIND_INSERT, 31'd3);
        send_op(KIND_INSERT, 31'd6);
        send_op(KIND_INSERT, 31'd4);
        send_op(KIND_INSERT, 31'd9);
        send_op(KIND_ERASE, 31'd3);
        send_op(KIND_SEARCH, 31'd4);

        // A zero count acts as one slot, and a count above the table
        // saturates; entries left from earlier settings stay in place.
        set_slot_count(11'd0);
        send_op(KIND_SEARCH, 31'd6);
        send_op(KIND_INSERT, 31'd12);
        set_slot_count(11'd2047);
        send_op(KIND_SEARCH, 31'h7FFF_FFFF);
        send_op(KIND_INSERT, 31'd2048);

        // Random phases through a range of table sizes, extremes included.
        run_phase(11'd2047, 300, 240);
        run_phase(11'd1, 4, 60);
        run_phase(11'd2, 6, 80);
        run_phase(11'd7, 14, 200);
        run_phase(11'd16, 30, 240);
        run_phase(11'd61, 90, 240);
        run_phase(11'd0, 3, 40);
        run_phase(11'd100, 150, 200);
        run_phase(11'd1024, 500, 220);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d items over %0d slot-count settings (0, 1, 2, 3 up to 1024 and 2047).",
                 items_sent, settings_used);
        $display("Inserts, searches, erases with back shifts, full tables and misses were checked.");
        if (fail_count == 0) begin
            $display("linear_probe_hash_table regression: pass");
        end else begin
            $display("linear_probe_hash_table regression: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #200ms;
        $display("Timed out with %0d items sent and %0d results outstanding.", items_sent, pending);
        $display("linear_probe_hash_table regression: fail");
        $finish;
    end

endmodule
